[design/crb_pkg.sv]
// ----------------------------------------------------------------------------
// crb_pkg: shared types and constants for the coalescing ring buffer
// Request/result payloads, status codes, sequencer states and cell control.
// ----------------------------------------------------------------------------
package crb_pkg;

  localparam int CRB_CAPACITY    = 16;
  localparam int CRB_KEY_WIDTH   = 32;
  localparam int CRB_VALUE_WIDTH = 32;

  typedef enum logic [2:0] {
    CRB_COALESCED = 3'd0,
    CRB_APPENDED  = 3'd1,
    CRB_REJECTED  = 3'd2,
    CRB_POLLED    = 3'd3,
    CRB_EMPTY     = 3'd4
  } crb_status_t;

  typedef enum logic [0:0] {
    CRB_CMD_OFFER = 1'b0,
    CRB_CMD_POLL  = 1'b1
  } crb_cmd_t;

  typedef enum logic {
    CRB_IDLE,
    CRB_POLL
  } crb_state_t;

  typedef struct packed {
    logic [0:0]  cmd;
    logic [31:0] entry_key;
    logic [31:0] entry_value;
    logic [4:0]  poll_limit;
  } crb_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_value;
    logic        last;
    logic [4:0]  polled_count;
    logic [4:0]  occupancy;
    logic [31:0] rejection_total;
  } crb_rsp_t;

  // Broadcast control to every cell of the chain
  typedef struct packed {
    logic offer;  // offer transfer this cycle
    logic hit;    // some pending entry has the offered key
    logic shift;  // every cell takes its upper neighbor's entry
  } crb_cell_ctl_t;

endpackage

[design/crb_cell.sv]
// ----------------------------------------------------------------------------
// crb_cell: one slot of the coalescing ring buffer chain
// Holds one entry, compares it with the offered key and shifts toward the head.
// ----------------------------------------------------------------------------
module crb_cell #(
  parameter int KEY_WIDTH   = crb_pkg::CRB_KEY_WIDTH,
  parameter int VALUE_WIDTH = crb_pkg::CRB_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  crb_pkg::crb_cell_ctl_t ctl,
  input  logic [KEY_WIDTH-1:0]   probe_key,
  input  logic [VALUE_WIDTH-1:0] offer_value,
  input  logic                   prev_valid,
  input  logic                   next_valid,
  input  logic [KEY_WIDTH-1:0]   next_key,
  input  logic [VALUE_WIDTH-1:0] next_value,
  output logic                   valid,
  output logic [KEY_WIDTH-1:0]   key,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   match
);

  logic load;

  // The first free cell after the occupied run takes a new entry
  assign load  = ctl.offer && !ctl.hit && !valid && prev_valid;
  assign match = valid && (key == probe_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= next_valid;
    end else if (load) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key   <= next_key;
      value <= next_value;
    end else if (ctl.offer && match) begin
      value <= offer_value;
    end else if (load) begin
      key   <= probe_key;
      value <= offer_value;
    end
  end

endmodule

[design/coalescing_ring_buffer.sv]
// ----------------------------------------------------------------------------
// coalescing_ring_buffer: FIFO of key/value entries that coalesce by key
// A chain of cells, oldest entry at the head, with a small poll sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred on a rising edge where start is high and busy is
//   low. cmd offer: the key is compared with all pending entries at once; a
//   match overwrites that value, otherwise the entry is appended, or rejected
//   when CAPACITY entries are pending. One result follows in the cycle after the
//   transfer. cmd poll: n = min(poll_limit, occupancy) entries leave the head
//   one per cycle; busy is high while they leave, and the n results arrive on
//   consecutive cycles, each registered from the head cell, the last one
//   marked by last. A poll that removes nothing gives one result in the cycle
//   after its transfer. Throughput: one offer per cycle while busy is low; a
//   poll holds the input (busy high) while the chain shifts one cell per cycle
//   toward the head.
//   Each result is shown for exactly one cycle with result_valid; the
//   receiver cannot stall it. Reset (rst, synchronous) empties the chain and
//   clears the rejection counter.
// ----------------------------------------------------------------------------
module coalescing_ring_buffer #(
  parameter int CAPACITY    = crb_pkg::CRB_CAPACITY,
  parameter int KEY_WIDTH   = crb_pkg::CRB_KEY_WIDTH,
  parameter int VALUE_WIDTH = crb_pkg::CRB_VALUE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  crb_pkg::crb_req_t request,
  output logic              result_valid,
  output crb_pkg::crb_rsp_t result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  crb_pkg::crb_state_t    state, state_next;
  crb_pkg::crb_cell_ctl_t ctl;

  logic [CW-1:0]          count, count_next, remaining, polled_n, poll_n;
  logic [31:0]            rejections, rejections_next;
  logic [CAPACITY-1:0]    valid_vec, match_vec;
  logic [KEY_WIDTH-1:0]   cell_key   [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic [KEY_WIDTH-1:0]   probe_key;
  logic [VALUE_WIDTH-1:0] offer_value;
  logic [31:0]            head_value;
  logic [LW-1:0]          lim_w, occ_w;
  logic                   accept, offer_acc, poll_acc, hit, full, shift;
  crb_pkg::crb_status_t   offer_status;

  generate
    if (KEY_WIDTH <= 32) begin : g_key_narrow
      assign probe_key = request.entry_key[KEY_WIDTH-1:0];
    end else begin : g_key_wide
      assign probe_key = {{(KEY_WIDTH-32){1'b0}}, request.entry_key};
    end
    if (VALUE_WIDTH <= 32) begin : g_val_narrow
      assign offer_value = request.entry_value[VALUE_WIDTH-1:0];
    end else begin : g_val_wide
      assign offer_value = {{(VALUE_WIDTH-32){1'b0}}, request.entry_value};
    end
    if (VALUE_WIDTH >= 32) begin : g_head_wide
      assign head_value = cell_value[0][31:0];
    end else begin : g_head_narrow
      assign head_value = {{(32-VALUE_WIDTH){1'b0}}, cell_value[0]};
    end
  endgenerate

  assign busy      = (state == crb_pkg::CRB_POLL);
  assign accept    = start && !busy;
  assign offer_acc = accept && (request.cmd == crb_pkg::CRB_CMD_OFFER);
  assign poll_acc  = accept && (request.cmd == crb_pkg::CRB_CMD_POLL);
  assign hit       = |match_vec;
  assign full      = (count == CW'(CAPACITY));

  assign ctl.offer = offer_acc;
  assign ctl.hit   = hit;
  assign ctl.shift = shift;

  // Entries removed by a poll: limit clipped to what is pending
  assign lim_w  = LW'(request.poll_limit);
  assign occ_w  = LW'(count);
  assign poll_n = (lim_w < occ_w) ? CW'(lim_w) : count;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                   prev_valid, next_valid;
      logic [KEY_WIDTH-1:0]   next_key;
      logic [VALUE_WIDTH-1:0] next_value;

      if (i == 0) begin : g_head
        assign prev_valid = 1'b1;
      end else begin : g_body
        assign prev_valid = valid_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign next_valid = 1'b0;
        assign next_key   = '0;
        assign next_value = '0;
      end else begin : g_link
        assign next_valid = valid_vec[i+1];
        assign next_key   = cell_key[i+1];
        assign next_value = cell_value[i+1];
      end

      crb_cell #(
        .KEY_WIDTH  (KEY_WIDTH),
        .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .probe_key  (probe_key),
        .offer_value(offer_value),
        .prev_valid (prev_valid),
        .next_valid (next_valid),
        .next_key   (next_key),
        .next_value (next_value),
        .valid      (valid_vec[i]),
        .key        (cell_key[i]),
        .value      (cell_value[i]),
        .match      (match_vec[i])
      );
    end
  endgenerate

  // Poll sequencer
  always_comb begin
    state_next = state;
    shift      = 1'b0;
    case (state)
      crb_pkg::CRB_IDLE: begin
        if (poll_acc && (poll_n != '0)) begin
          state_next = crb_pkg::CRB_POLL;
        end
      end
      crb_pkg::CRB_POLL: begin
        shift = 1'b1;
        if (remaining == CW'(1)) begin
          state_next = crb_pkg::CRB_IDLE;
        end
      end
      default: begin
        state_next = crb_pkg::CRB_IDLE;
      end
    endcase
  end

  always_comb begin
    count_next      = count;
    rejections_next = rejections;
    offer_status    = crb_pkg::CRB_APPENDED;
    if (hit) begin
      offer_status = crb_pkg::CRB_COALESCED;
    end else if (full) begin
      offer_status = crb_pkg::CRB_REJECTED;
    end
    if (offer_acc && !hit) begin
      if (full) begin
        rejections_next = (rejections == '1) ? rejections : rejections + 32'd1;
      end else begin
        count_next = count + CW'(1);
      end
    end else if (poll_acc) begin
      count_next = count - poll_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= crb_pkg::CRB_IDLE;
      count        <= '0;
      rejections   <= '0;
      remaining    <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      rejections   <= rejections_next;
      result_valid <= offer_acc || (poll_acc && (poll_n == '0)) || busy;
      if (poll_acc) begin
        remaining <= poll_n;
      end else if (busy) begin
        remaining <= remaining - CW'(1);
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (poll_acc) begin
      polled_n <= poll_n;
    end
    if (offer_acc) begin
      result.status          <= offer_status;
      result.out_value       <= '0;
      result.last            <= 1'b1;
      result.polled_count    <= '0;
      result.occupancy       <= 5'(count_next);
      result.rejection_total <= rejections_next;
    end else if (poll_acc) begin
      result.status          <= crb_pkg::CRB_EMPTY;
      result.out_value       <= '0;
      result.last            <= 1'b1;
      result.polled_count    <= '0;
      result.occupancy       <= 5'(count_next);
      result.rejection_total <= rejections;
    end else if (busy) begin
      result.status          <= crb_pkg::CRB_POLLED;
      result.out_value       <= head_value;
      result.last            <= (remaining == CW'(1));
      result.polled_count    <= 5'(polled_n);
      result.occupancy       <= 5'(count);
      result.rejection_total <= rejections;
    end
  end

`ifndef ASSERT_OFF
  // Pending keys are unique, so at most one cell can match
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("more than one cell matches the offered key");

  // Occupied cells form one run starting at the head
  a_packed_chain: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + CAPACITY'(1))) == '0)
    else $error("gap in the occupied cells");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (state == crb_pkg::CRB_IDLE) |-> ($countones(valid_vec) == int'(count)))
    else $error("occupancy count disagrees with the cells");

  a_poll_emits: assert property (@(posedge clk) disable iff (rst)
    (state == crb_pkg::CRB_POLL) |=> (result_valid &&
      (result.status == crb_pkg::CRB_POLLED)))
    else $error("poll cycle without a polled result");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    (state == crb_pkg::CRB_POLL) |-> valid_vec[0])
    else $error("polling an empty head cell");
`endif

endmodule

[sim/coalescing_ring_buffer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_ring_buffer_test: self-checking bench for the coalescing buffer
// A directed table of offers and polls, then random traffic with a small key
// pool. Every result is checked, against a queue model of the pending entries or a typed row's rsp.
// ----------------------------------------------------------------------------
module coalescing_ring_buffer_test;

  localparam int CAP          = crb_pkg::CRB_CAPACITY;
  localparam int RANDOM_ITEMS = 190;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [31:0] key;
    logic [31:0] value;
  } entry_t;

  typedef struct {
    crb_pkg::crb_req_t req;
    int                reps;   // issued reps times, key and value stepped by one
    bit                typed;  // use rsp below instead of the model
    crb_pkg::crb_rsp_t rsp;
  } plan_row_t;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              start   = 1'b0;
  crb_pkg::crb_req_t request = '0;
  logic              busy;
  logic              result_valid;
  crb_pkg::crb_rsp_t result;

  entry_t            held[$];           // pending entries, oldest first
  logic [31:0]       rejected_offers = '0;
  crb_pkg::crb_rsp_t fresh_rsp[$];      // results of the latest command
  crb_pkg::crb_rsp_t rsp_due[$];        // results still to arrive
  int                fail_count  = 0;
  int                cycle_count = 0;
  bit                gaps_on     = 1'b1;

  coalescing_ring_buffer u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic crb_pkg::crb_req_t offer(logic [31:0] k, logic [31:0] v);
    crb_pkg::crb_req_t r;
    r             = '0;
    r.cmd         = crb_pkg::CRB_CMD_OFFER;
    r.entry_key   = k;
    r.entry_value = v;
    return r;
  endfunction

  function automatic crb_pkg::crb_req_t poll(logic [4:0] lim);
    crb_pkg::crb_req_t r;
    r            = '0;
    r.cmd        = crb_pkg::CRB_CMD_POLL;
    r.poll_limit = lim;
    return r;
  endfunction

  // single-result outcome: offers and empty polls
  function automatic crb_pkg::crb_rsp_t single(crb_pkg::crb_status_t s, int occ,
                                               logic [31:0] rej);
    crb_pkg::crb_rsp_t o;
    o                 = '0;
    o.status          = s;
    o.last            = 1'b1;
    o.occupancy       = 5'(occ);
    o.rejection_total = rej;
    return o;
  endfunction

  // Updates the entry model for one command and fills fresh_rsp
  function automatic void apply_command(crb_pkg::crb_req_t r);
    crb_pkg::crb_rsp_t o;
    int                hit;
    int                n;
    fresh_rsp.delete();
    o      = '0;
    o.last = 1'b1;
    if (r.cmd == crb_pkg::CRB_CMD_OFFER) begin
      hit = -1;
      foreach (held[i]) if (hit < 0 && held[i].key == r.entry_key) hit = i;
      if (hit >= 0) begin
        held[hit].value = r.entry_value;
        o.status        = crb_pkg::CRB_COALESCED;
      end else if (held.size() >= CAP) begin
        if (rejected_offers != '1) rejected_offers++;
        o.status = crb_pkg::CRB_REJECTED;
      end else begin
        held.push_back('{r.entry_key, r.entry_value});
        o.status = crb_pkg::CRB_APPENDED;
      end
      o.occupancy       = 5'(held.size());
      o.rejection_total = rejected_offers;
      fresh_rsp.push_back(o);
    end else begin
      n = int'(r.poll_limit);
      if (n > held.size()) n = held.size();
      if (n > CAP) n = CAP;
      o.rejection_total = rejected_offers;
      o.occupancy       = 5'(held.size() - n);
      if (n == 0) begin
        o.status = crb_pkg::CRB_EMPTY;
        fresh_rsp.push_back(o);
      end else begin
        for (int k = 0; k < n; k++) begin
          o.status       = crb_pkg::CRB_POLLED;
          o.out_value    = held.pop_front().value;
          o.polled_count = 5'(n);
          o.last         = (k == n - 1);
          fresh_rsp.push_back(o);
        end
      end
    end
  endfunction

  // Called right after a rising edge; returns at the edge of the transfer
  task automatic issue(crb_pkg::crb_req_t r, bit typed, crb_pkg::crb_rsp_t typed_rsp);
    if (gaps_on && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    apply_command(r);
    if (typed) rsp_due.push_back(typed_rsp);
    else foreach (fresh_rsp[i]) rsp_due.push_back(fresh_rsp[i]);
  endtask

  task automatic drain_wait();
    start <= 1'b0;
    do @(posedge clk); while (rsp_due.size() != 0);
  endtask

  always @(posedge clk) begin : rsp_check
    crb_pkg::crb_rsp_t want;
    if (!rst && result_valid) begin
      if (rsp_due.size() == 0) begin
        $error("unexpected result: status %0d value %0h", result.status, result.out_value);
        fail_count++;
      end else begin
        want = rsp_due.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          fail_count++;
        end
        if (result.out_value !== want.out_value) begin
          $error("out_value: expected %0h, got %0h", want.out_value, result.out_value);
          fail_count++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result.last);
          fail_count++;
        end
        if (result.polled_count !== want.polled_count) begin
          $error("polled_count: expected %0d, got %0d", want.polled_count,
                 result.polled_count);
          fail_count++;
        end
        if (result.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, result.occupancy);
          fail_count++;
        end
        if (result.rejection_total !== want.rejection_total) begin
          $error("rejection_total: expected %0d, got %0d", want.rejection_total,
                 result.rejection_total);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** coalescing_ring_buffer: FAILED **");
      $finish;
    end
  end

  initial begin
    plan_row_t         plan[$];
    crb_pkg::crb_req_t r;
    int                fill_bias;

    plan.push_back('{poll(5'd0), 1, 1'b1, single(crb_pkg::CRB_EMPTY, 0, 0)});
    plan.push_back('{poll(5'd31), 1, 1'b1, single(crb_pkg::CRB_EMPTY, 0, 0)});
    plan.push_back('{offer(32'h0, 32'hFFFF_FFFF), 1, 1'b1,
                     single(crb_pkg::CRB_APPENDED, 1, 0)});
    plan.push_back('{offer(32'hFFFF_FFFF, 32'h0), 1, 1'b1,
                     single(crb_pkg::CRB_APPENDED, 2, 0)});
    plan.push_back('{offer(32'h0, 32'h1234_5678), 1, 1'b1,
                     single(crb_pkg::CRB_COALESCED, 2, 0)});
    plan.push_back('{offer(32'hFFFF_FFFF, 32'hA5A5_A5A5), 1, 1'b1,
                     single(crb_pkg::CRB_COALESCED, 2, 0)});
    plan.push_back('{poll(5'd0), 1, 1'b1, single(crb_pkg::CRB_EMPTY, 2, 0)});
    // limit above occupancy takes only what is pending
    plan.push_back('{poll(5'd31), 1, 1'b0, '0});
    plan.push_back('{offer(32'h0, 32'h5), 1, 1'b1, single(crb_pkg::CRB_APPENDED, 1, 0)});
    plan.push_back('{poll(5'd1), 1, 1'b0, '0});
    plan.push_back('{offer(32'h100, 32'hC000_0000), CAP, 1'b0, '0});
    plan.push_back('{offer(32'hDEAD_BEEF, 32'h1), 1, 1'b1,
                     single(crb_pkg::CRB_REJECTED, CAP, 1)});
    // matching key still coalesces while full
    plan.push_back('{offer(32'h10F, 32'h7777), 1, 1'b1,
                     single(crb_pkg::CRB_COALESCED, CAP, 1)});
    plan.push_back('{offer(32'h100, 32'h3333_CCCC), 1, 1'b1,
                     single(crb_pkg::CRB_COALESCED, CAP, 1)});
    plan.push_back('{offer(32'hFFFF_FFFE, 32'h2), 1, 1'b1,
                     single(crb_pkg::CRB_REJECTED, CAP, 2)});
    plan.push_back('{poll(5'd3), 1, 1'b0, '0});
    plan.push_back('{offer(32'h5555_5555, 32'h5555_5555), 3, 1'b0, '0});
    plan.push_back('{offer(32'hAAAA_AAAA, 32'hAAAA_AAAA), 1, 1'b1,
                     single(crb_pkg::CRB_REJECTED, CAP, 3)});
    plan.push_back('{poll(5'd16), 1, 1'b0, '0});
    plan.push_back('{poll(5'd5), 1, 1'b1, single(crb_pkg::CRB_EMPTY, 0, 3)});
    plan.push_back('{offer(32'h8000_0001, 32'h7FFF_FFFE), 1, 1'b1,
                     single(crb_pkg::CRB_APPENDED, 1, 3)});
    plan.push_back('{poll(5'd10), 1, 1'b0, '0});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      for (int j = 0; j < plan[i].reps; j++) begin
        r              = plan[i].req;
        r.entry_key   += j;
        r.entry_value += j;
        issue(r, plan[i].typed, plan[i].rsp);
      end
    end
    drain_wait();

    fill_bias = 85;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // switch at random between filling and draining spells so the full case recurs
      if (n % 20 == 0) fill_bias = $urandom_range(0, 1) ? 85 : 35;
      gaps_on = !(n >= 80 && n < 160);
      if (n == 120) drain_wait();
      r.cmd         = ($urandom_range(0, 99) < fill_bias) ? crb_pkg::CRB_CMD_OFFER
                                                          : crb_pkg::CRB_CMD_POLL;
      r.entry_key   = ($urandom_range(0, 99) < 60) ? 32'h1000 + $urandom_range(0, 23)
                                                   : $urandom();
      r.entry_value = $urandom();
      r.poll_limit  = ($urandom_range(0, 99) < 70) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(1, 4));
      issue(r, 1'b0, '0);
    end

    drain_wait();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("** coalescing_ring_buffer: PASSED **");
    end else begin
      $display("** coalescing_ring_buffer: FAILED **");
    end
    $finish;
  end

endmodule
